FILE: rtl/a2b_pkg.sv
// Shared types and constants for the AVCC to Annex B converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package a2b_pkg;

  // Annex B start code, sent most significant byte first.
  localparam logic [31:0] START_CODE = 32'h0000_0001;
  localparam logic [3:0]  AVC_CODEC  = 4'd7;
  localparam logic [7:0]  PKT_SEQ_HDR = 8'd0;
  localparam logic [7:0]  PKT_NALU    = 8'd1;
  localparam logic [1:0]  LEN_SIZE_MASK = 2'b11;

  // Tag body byte positions that matter.
  localparam logic [3:0] POS_PKT_TYPE  = 4'd1;
  localparam logic [3:0] POS_NALU_DATA = 4'd5;
  localparam logic [3:0] POS_LEN_SIZE  = 4'd9;
  localparam logic [3:0] POS_SPS_LEN   = 4'd11;
  localparam logic [3:0] POS_MAX       = 4'd15;

  // Length field sizes inside a sequence header.
  localparam logic [2:0] SPS_LEN_BYTES = 3'd2;
  localparam logic [2:0] PPS_LEN_BYTES = 3'd3;
  localparam logic [2:0] PREFIX_RESET  = 3'd4;

  typedef enum logic [3:0] {
    MODE_SKIP = 4'b0001,
    MODE_SEQ  = 4'b0010,
    MODE_NALU = 4'b0100,
    MODE_WAIT = 4'b1000
  } tag_mode_e;

  typedef enum logic [3:0] {
    SEC_LEN     = 4'b0001,
    SEC_PAY     = 4'b0010,
    SEC_PPS_LEN = 4'b0100,
    SEC_PPS_PAY = 4'b1000
  } section_e;

  // One queued job: either a whole start code or a single payload byte.
  typedef struct packed {
    logic       is_start;
    logic [7:0] data;
  } job_t;

  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    logic [4:0] sh;
    sh = {~idx, 3'b000};
    return START_CODE[sh +: 8];
  endfunction

endpackage

FILE: rtl/a2b_front.sv
// Front end: parses FLV video tag bytes and queues start code or byte jobs.
// Depends on a2b_pkg.
`timescale 1ns / 1ps

module a2b_front import a2b_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tag_valid_i,
  output logic       tag_ready_o,
  input  logic [7:0] tag_byte_i,
  input  logic       tag_first_i,
  input  logic       tag_last_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output job_t       push_job_o
);

  logic [3:0]  pos_q, pos_d;
  tag_mode_e   mode_q, mode_d;
  section_e    sec_q, sec_d;
  logic [2:0]  prefix_q, prefix_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  seen_q, seen_d;
  logic [31:0] rem_q, rem_d;

  logic        accept;
  logic        unit;
  logic        emit_start;
  logic        emit_data;
  logic [31:0] acc_next;
  logic [2:0]  seen_next;
  logic [2:0]  need;
  logic [31:0] len;
  logic        in_payload;

  assign tag_ready_o = !queue_full_i;
  assign accept      = tag_valid_i && tag_ready_o;
  assign in_payload  = (sec_q == SEC_PAY) || (sec_q == SEC_PPS_PAY);
  assign acc_next    = {acc_q[23:0], tag_byte_i};
  assign seen_next   = seen_q + 3'd1;

  always_comb begin
    if (mode_q == MODE_NALU) begin
      need = prefix_q;
      len  = acc_next;
    end else begin
      need = (sec_q == SEC_LEN) ? SPS_LEN_BYTES : PPS_LEN_BYTES;
      len  = {16'h0000, acc_next[15:0]};
    end
  end

  always_comb begin
    pos_d      = pos_q;
    mode_d     = mode_q;
    sec_d      = sec_q;
    prefix_d   = prefix_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    rem_d      = rem_q;
    unit       = 1'b0;
    emit_start = 1'b0;
    emit_data  = 1'b0;

    if (tag_first_i) begin
      pos_d  = POS_PKT_TYPE;
      sec_d  = SEC_LEN;
      acc_d  = '0;
      seen_d = '0;
      rem_d  = '0;
      mode_d = (tag_byte_i[3:0] == AVC_CODEC) ? MODE_WAIT : MODE_SKIP;
    end else begin
      if (pos_q < POS_MAX) begin
        pos_d = pos_q + 4'd1;
      end
      case (mode_q)
        MODE_WAIT: begin
          if (pos_q == POS_PKT_TYPE && tag_byte_i == PKT_SEQ_HDR) begin
            mode_d = MODE_SEQ;
          end else if (pos_q == POS_PKT_TYPE && tag_byte_i == PKT_NALU) begin
            mode_d = MODE_NALU;
          end else begin
            mode_d = MODE_SKIP;
          end
        end
        MODE_SEQ: begin
          if (pos_q < POS_SPS_LEN) begin
            if (pos_q == POS_LEN_SIZE) begin
              prefix_d = {1'b0, tag_byte_i[1:0] & LEN_SIZE_MASK} + 3'd1;
            end
          end else begin
            unit = 1'b1;
          end
        end
        MODE_NALU: begin
          unit = (pos_q >= POS_NALU_DATA);
        end
        default: ;
      endcase

      if (unit) begin
        if (!in_payload) begin
          if (seen_next >= need) begin
            emit_start = 1'b1;
            acc_d      = '0;
            seen_d     = '0;
            rem_d      = len;
          end else begin
            acc_d  = acc_next;
            seen_d = seen_next;
          end
        end else begin
          emit_data = 1'b1;
          rem_d     = rem_q - 32'd1;
        end

        // Advance the section when a length field or a payload completes;
        // a zero length field completes its unit at once.
        if (emit_start && len != 32'd0) begin
          sec_d = (sec_q == SEC_LEN) ? SEC_PAY : SEC_PPS_PAY;
        end else if ((emit_start && len == 32'd0) || (emit_data && rem_q == 32'd1)) begin
          if (mode_q == MODE_NALU) begin
            sec_d = SEC_LEN;
          end else if (sec_q == SEC_LEN || sec_q == SEC_PAY) begin
            sec_d = SEC_PPS_LEN;
          end else begin
            mode_d = MODE_SKIP;
            sec_d  = SEC_LEN;
          end
        end
      end
    end

    if (tag_last_i) begin
      mode_d = MODE_SKIP;
    end
  end

  assign push_o              = accept && (emit_start || emit_data);
  assign push_job_o.is_start = emit_start;
  assign push_job_o.data     = tag_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      mode_q   <= MODE_SKIP;
      sec_q    <= SEC_LEN;
      prefix_q <= PREFIX_RESET;
      acc_q    <= '0;
      seen_q   <= '0;
      rem_q    <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      mode_q   <= mode_d;
      sec_q    <= sec_d;
      prefix_q <= prefix_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      rem_q    <= rem_d;
    end
  end

endmodule

FILE: rtl/a2b_fifo.sv
// Short job queue between the parser and the byte emitter.
// Depends on a2b_pkg for the job type.
`timescale 1ns / 1ps

module a2b_fifo import a2b_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FULL_CNT);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: rtl/a2b_back.sv
// Back end: expands queued jobs into output bytes, one per cycle while the output is ready.
// Depends on a2b_pkg.
`timescale 1ns / 1ps

module a2b_back import a2b_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       unit_start_o,
  output logic       run_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       start_q, start_d;
  logic       last_q, last_d;
  logic       load;

  // The output register is free when empty or when its transaction completes.
  assign load = !valid_q || out_ready_i;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    start_d = start_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.is_start) begin
          byte_d  = start_code_byte(idx_q);
          start_d = (idx_q == 2'd0);
          last_d  = (idx_q == 2'd3);
          pop_o   = (idx_q == 2'd3);
          idx_d   = idx_q + 2'd1;
        end else begin
          byte_d  = head_i.data;
          start_d = 1'b0;
          last_d  = 1'b1;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign unit_start_o = start_q;
  assign run_last_o   = last_q;

endmodule

FILE: rtl/avcc_to_annexb_converter.sv
// AVCC to Annex B converter for FLV video tag bodies. The block takes one tag
// byte per cycle and produces the H.264 Annex B stream one byte per cycle while
// the output is ready. A parser front end accepts a byte whenever its job queue
// has room and turns it into at most one job; a payload byte becomes one output
// byte and a completed length field becomes a four-byte start code 00 00 00 01.
// The job made from an accepted input byte is written into the queue and then
// loaded into the output register. Throughput is one input byte per cycle while
// output bytes drain at the same rate; each start code occupies the output
// register for its four bytes, and the QUEUE_DEPTH-entry queue absorbs those
// bursts, so a tag with many short units can backpressure the input.
// Depends on a2b_pkg, a2b_front, a2b_fifo and a2b_back.
`timescale 1ns / 1ps

module avcc_to_annexb_converter import a2b_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tag_valid_i,
  output logic       tag_ready_o,
  input  logic [7:0] tag_byte_i,
  input  logic       tag_first_i,
  input  logic       tag_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       unit_start_o,
  output logic       run_last_o
);

  logic push;
  job_t push_job;
  logic pop;
  job_t head;
  logic empty;
  logic full;

  a2b_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_valid_i  (tag_valid_i),
    .tag_ready_o  (tag_ready_o),
    .tag_byte_i   (tag_byte_i),
    .tag_first_i  (tag_first_i),
    .tag_last_i   (tag_last_i),
    .queue_full_i (full),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  a2b_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  a2b_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .unit_start_o (unit_start_o),
    .run_last_o   (run_last_o)
  );

endmodule

FILE: tb/sv/tb_avcc_to_annexb_converter.sv
// Self-checking testbench for avcc_to_annexb_converter: FLV video tag bytes in,
// Annex B stream bytes out, each output transaction checked against a predictor.
// Depends on a2b_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_avcc_to_annexb_converter;
  import a2b_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 95;
  localparam int QUIET_AFTER    = 75;
  localparam int HOLD_AFTER     = 20;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       unit_first;
    logic       step_last;
  } out_item_t;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_START, EXP_COPY} exp_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       f_mark;
    logic       l_mark;
    exp_kind_e  kind;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       tag_valid_i = 1'b0;
  logic       tag_ready_o;
  logic [7:0] tag_byte_i = 8'h00;
  logic       tag_first_i = 1'b0;
  logic       tag_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       unit_start_o;
  logic       run_last_o;

  always #5 clk_i = ~clk_i;

  avcc_to_annexb_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_valid_i  (tag_valid_i),
    .tag_ready_o  (tag_ready_o),
    .tag_byte_i   (tag_byte_i),
    .tag_first_i  (tag_first_i),
    .tag_last_i   (tag_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .unit_start_o (unit_start_o),
    .run_last_o   (run_last_o)
  );

  // Converter state as the predictor sees it.
  logic [3:0]  tag_pos = 4'd0;
  tag_mode_e   tag_mode_now = MODE_SKIP;
  section_e    unit_part = SEC_LEN;
  logic [2:0]  len_size = PREFIX_RESET;
  logic [31:0] len_acc = 32'd0;
  logic [2:0]  len_seen = 3'd0;
  logic [31:0] body_left = 32'd0;

  out_item_t   step_bytes [4];
  out_item_t   annexb_expected [$];
  logic [7:0]  tag_body [$];
  int          errors = 0;
  int          bytes_seen = 0;
  int          idle_cycles = 0;
  int          items_sent = 0;
  bit          quiet = 1'b0;

  // Directed tags: a dropped non-AVC tag, a sequence header with one SPS and an
  // empty PPS, a stray byte, then a NALU packet with one-byte length prefixes.
  stim_row_t directed_rows [28] = '{
    '{8'h0a, 1'b1, 1'b0, EXP_NONE},
    '{8'h17, 1'b1, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h01, 1'b0, 1'b0, EXP_NONE},
    '{8'h64, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h1f, 1'b0, 1'b0, EXP_NONE},
    '{8'hfc, 1'b0, 1'b0, EXP_NONE},
    '{8'he1, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h01, 1'b0, 1'b0, EXP_START},
    '{8'hff, 1'b0, 1'b0, EXP_COPY},
    '{8'h01, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_START},
    '{8'h68, 1'b0, 1'b1, EXP_NONE},
    '{8'hff, 1'b0, 1'b0, EXP_NONE},
    '{8'h27, 1'b1, 1'b0, EXP_NONE},
    '{8'h01, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h00, 1'b0, 1'b0, EXP_NONE},
    '{8'h02, 1'b0, 1'b0, EXP_START},
    '{8'h00, 1'b0, 1'b0, EXP_MODEL},
    '{8'hff, 1'b0, 1'b1, EXP_COPY}
  };

  // Advances to the next unit once a payload is complete. In a sequence header
  // the SPS is followed by the PPS, and after the PPS the tag is ignored.
  function automatic void next_unit();
    if (tag_mode_now == MODE_NALU) begin
      unit_part = SEC_LEN;
    end else if (unit_part == SEC_LEN || unit_part == SEC_PAY) begin
      unit_part = SEC_PPS_LEN;
    end else begin
      tag_mode_now = MODE_SKIP;
      unit_part = SEC_LEN;
    end
  endfunction

  function automatic int take_unit_byte(input logic [7:0] b);
    int n;
    int i;
    logic [2:0] need;
    logic [31:0] len;
    n = 0;
    if (unit_part == SEC_LEN || unit_part == SEC_PPS_LEN) begin
      len_acc = {len_acc[23:0], b};
      len_seen = len_seen + 3'd1;
      if (tag_mode_now == MODE_NALU) begin
        need = len_size;
      end else begin
        need = (unit_part == SEC_LEN) ? SPS_LEN_BYTES : PPS_LEN_BYTES;
      end
      if (len_seen >= need) begin
        len = len_acc;
        // The PPS count byte lands in bits 23:16 and is thrown away here.
        if (tag_mode_now != MODE_NALU) begin
          len = {16'd0, len[15:0]};
        end
        for (i = 0; i < 4; i++) begin
          step_bytes[i] = out_item_t'{START_CODE[31 - 8 * i -: 8], i == 0, 1'b0};
        end
        n = 4;
        len_acc = 32'd0;
        len_seen = 3'd0;
        body_left = len;
        if (len != 32'd0) begin
          unit_part = (unit_part == SEC_LEN) ? SEC_PAY : SEC_PPS_PAY;
        end else begin
          next_unit();
        end
      end
    end else begin
      step_bytes[0] = out_item_t'{b, 1'b0, 1'b0};
      n = 1;
      body_left = body_left - 32'd1;
      if (body_left == 32'd0) begin
        next_unit();
      end
    end
    return n;
  endfunction

  // Predicts the output bytes caused by one accepted input byte.
  function automatic int annexb_convert(input logic [7:0] b, input bit f_mark,
                                        input bit l_mark);
    int n;
    logic [3:0] p;
    n = 0;
    if (f_mark) begin
      tag_pos = 4'd1;
      unit_part = SEC_LEN;
      len_acc = 32'd0;
      len_seen = 3'd0;
      body_left = 32'd0;
      tag_mode_now = (b[3:0] == AVC_CODEC) ? MODE_WAIT : MODE_SKIP;
    end else begin
      p = tag_pos;
      if (tag_pos < POS_MAX) begin
        tag_pos = tag_pos + 4'd1;
      end
      case (tag_mode_now)
        MODE_WAIT: begin
          if (p == POS_PKT_TYPE && b == PKT_SEQ_HDR) begin
            tag_mode_now = MODE_SEQ;
          end else if (p == POS_PKT_TYPE && b == PKT_NALU) begin
            tag_mode_now = MODE_NALU;
          end else begin
            tag_mode_now = MODE_SKIP;
          end
        end
        MODE_SEQ: begin
          if (p < POS_SPS_LEN) begin
            if (p == POS_LEN_SIZE) begin
              len_size = {1'b0, b[1:0]} + 3'd1;
            end
          end else begin
            n = take_unit_byte(b);
          end
        end
        MODE_NALU: begin
          if (p >= POS_NALU_DATA) begin
            n = take_unit_byte(b);
          end
        end
        default: ;
      endcase
    end
    if (l_mark) begin
      tag_mode_now = MODE_SKIP;
    end
    if (n > 0) begin
      step_bytes[n - 1].step_last = 1'b1;
    end
    return n;
  endfunction

  // Appends one byte to the tag body being assembled.
  function automatic void add_byte(input logic [7:0] b);
    tag_body.insert(tag_body.size(), b);
  endfunction

  // Appends one expected output transaction.
  function automatic void expect_item(input out_item_t item);
    annexb_expected.insert(annexb_expected.size(), item);
  endfunction

  function automatic void push_random(input int count);
    repeat (count) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // Big-endian length field of the given size.
  function automatic void push_len(input logic [31:0] v, input int nbytes);
    int j;
    for (j = nbytes - 1; j >= 0; j--) begin
      add_byte(v[8 * j +: 8]);
    end
  endfunction

  // Offers one byte, waits for the transaction, then records what it should cause.
  // Called at a rising edge; returns at the edge where the byte was accepted.
  task automatic send_item(input logic [7:0] b, input bit f_mark, input bit l_mark,
                           input exp_kind_e kind);
    int n;
    int i;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      tag_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    tag_valid_i <= 1'b1;
    tag_byte_i <= b;
    tag_first_i <= f_mark;
    tag_last_i <= l_mark;
    do @(posedge clk_i); while (!tag_ready_o);
    items_sent++;
    n = annexb_convert(b, f_mark, l_mark);
    case (kind)
      EXP_MODEL: begin
        for (i = 0; i < n; i++) expect_item(step_bytes[i]);
      end
      EXP_START: begin
        for (i = 0; i < 4; i++) begin
          expect_item(out_item_t'{(i == 3) ? 8'h01 : 8'h00, i == 0, i == 3});
        end
      end
      EXP_COPY: expect_item(out_item_t'{b, 1'b0, 1'b1});
      default: ;
    endcase
  endtask

  // Sends the assembled tag body; an open tag gets no last mark.
  task automatic send_tag(input bit open_tag);
    int i;
    for (i = 0; i < tag_body.size(); i++) begin
      send_item(tag_body[i], i == 0, !open_tag && i == tag_body.size() - 1, EXP_MODEL);
    end
  endtask

  initial begin
    int pick;
    int keep;
    logic [31:0] ulen;
    logic [7:0] hdr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].data, directed_rows[r].f_mark, directed_rows[r].l_mark,
                directed_rows[r].kind);
    end

    while (items_sent < ITEM_TARGET) begin
      quiet = (items_sent >= QUIET_AFTER);
      tag_body.delete();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        add_byte({4'($urandom_range(0, 15)), AVC_CODEC});
        add_byte((pick < 15) ? PKT_SEQ_HDR : PKT_NALU);
        push_random(3);
        if (pick < 15) begin
          // Sequence header: fixed record head, then one SPS and one PPS.
          add_byte(8'h01);
          push_random(5);
          ulen = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 65535))
                                             : 32'($urandom_range(0, 4));
          push_len(ulen, 2);
          push_random((ulen > 8) ? 8 : int'(ulen));
          add_byte(8'($urandom_range(0, 255)));
          ulen = 32'($urandom_range(0, 4));
          push_len(ulen, 2);
          push_random(int'(ulen));
          push_random($urandom_range(0, 2));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            ulen = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 6));
            push_len(ulen, int'(len_size));
            // Huge lengths are simply cut off by the end of the tag.
            push_random((ulen > 8) ? 8 : int'(ulen));
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          keep = $urandom_range(2, tag_body.size() - 1);
          while (tag_body.size() > keep) void'(tag_body.pop_back());
        end
        send_tag($urandom_range(0, 9) == 0);
      end else if (pick < 92) begin
        // Either a non-AVC codec or an AVC tag with an unknown packet type.
        hdr = 8'($urandom_range(0, 255));
        if (pick < 85) begin
          if (hdr[3:0] == AVC_CODEC) hdr[0] = 1'b0;
          add_byte(hdr);
        end else begin
          add_byte({hdr[7:4], AVC_CODEC});
          add_byte(8'($urandom_range(2, 255)));
        end
        push_random($urandom_range(0, 4));
        send_tag($urandom_range(0, 3) == 0);
      end else begin
        // Stray bytes between tags.
        repeat ($urandom_range(1, 3)) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), EXP_MODEL);
        end
      end
    end

    tag_valid_i <= 1'b0;
    while (annexb_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Output side: checks every transaction and drives ready with random stalls,
  // plus one long hold-off that lets the block fill up and stall its input.
  initial begin
    int stall_left;
    int hold_left;
    bit held;
    out_item_t want;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        bytes_seen++;
        if (annexb_expected.size() == 0) begin
          $display("%0t: unexpected output: expected none, got byte %02h start %0b last %0b",
                   $time, out_byte_o, unit_start_o, run_last_o);
          errors++;
        end else begin
          want = annexb_expected.pop_front();
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte_o);
            errors++;
          end
          if (unit_start_o !== want.unit_first) begin
            $display("%0t: unit_start expected %0b, got %0b", $time, want.unit_first,
                     unit_start_o);
            errors++;
          end
          if (run_last_o !== want.step_last) begin
            $display("%0t: run_last expected %0b, got %0b", $time, want.step_last,
                     run_last_o);
            errors++;
          end
        end
      end
      if (!held && bytes_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && rst_ni && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((tag_valid_i && tag_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
